[hw/rtl/itcr_pkg.sv]
// Shared types and constants for the IPv4/TCP checksum recalculation core.
// Used by itcr_accum, itcr_final and ipv4_tcp_checksum_recalc_core; no dependencies.
package itcr_pkg;

  // Header field offsets in bytes, counted from the start of the IPv4 header
  localparam logic [15:0] IP_CSUM_OFF   = 16'd10;
  localparam logic [15:0] IP_SADDR_OFF  = 16'd12;
  localparam logic [15:0] IP_OPTS_OFF   = 16'd20;
  localparam logic [6:0]  TCP_CSUM_REL  = 7'd16;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
  localparam logic [15:0] PROTO_TCP     = 16'd6;

  // Port widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // Per-packet summary handed from the accumulator to the result register
  typedef struct packed {
    logic [15:0] header_sum;
    logic [15:0] segment_sum;
    logic [15:0] total_length;
    logic [5:0]  header_bytes;
    logic        truncated;
  } itcr_sum_t;

endpackage

[hw/rtl/itcr_accum.sv]
// Running state and per-byte ones'-complement accumulation of both checksums.
// Depends on itcr_pkg for field offsets and the packet summary type.
module itcr_accum
  import itcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_valid,
  input  logic [7:0] step_byte,
  input  logic       step_last,
  output itcr_sum_t  summary
);

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [5:0]  header_bytes_r, header_bytes_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [15:0] header_sum_r, header_sum_nxt;
  logic [15:0] segment_sum_r, segment_sum_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [5:0]  hl_raw;
  logic [5:0]  hb_cur;
  logic [15:0] tl_cur;
  logic [16:0] next_off;
  logic        in_packet;
  logic        odd_byte;
  logic        do_add;
  logic [15:0] even_off;
  logic [15:0] word;
  logic [15:0] tcp_csum_off;
  logic        hdr_region;
  logic        add_hdr;
  logic        add_seg;
  logic [15:0] hdr_sum_add;
  logic [15:0] seg_sum_add;

  // End-around carry add of two 16-bit words
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      oc_add = s[15:0] + {15'd0, s[16]};
    end
  endfunction

  // Pick up header length and total length as their bytes pass
  always_comb begin
    hl_raw = {step_byte[3:0], 2'b00};
    hb_cur = header_bytes_r;
    tl_cur = total_length_r;
    if (byte_offset_r == 16'd0) begin
      hb_cur = (hl_raw < MIN_HDR_BYTES) ? MIN_HDR_BYTES : hl_raw;
    end else if (byte_offset_r == 16'd2) begin
      tl_cur = {step_byte, 8'd0};
    end else if (byte_offset_r == 16'd3) begin
      tl_cur = {total_length_r[15:8], step_byte};
    end
  end

  // Decide whether this byte completes a word and where that word belongs
  always_comb begin
    next_off     = {1'b0, byte_offset_r} + 17'd1;
    odd_byte     = byte_offset_r[0];
    in_packet    = (byte_offset_r < 16'd4) || (byte_offset_r < tl_cur);
    do_add       = in_packet && (odd_byte || step_last ||
                   ((byte_offset_r >= 16'd4) && (next_off == {1'b0, tl_cur})));
    even_off     = {byte_offset_r[15:1], 1'b0};
    word         = odd_byte ? {held_r, step_byte} : {step_byte, 8'd0};
    tcp_csum_off = {9'd0, {1'b0, hb_cur} + TCP_CSUM_REL};
    hdr_region   = even_off < {10'd0, hb_cur};
    add_hdr      = do_add && hdr_region && (even_off != IP_CSUM_OFF);
    add_seg      = do_add && (hdr_region ?
                   ((even_off >= IP_SADDR_OFF) && (even_off < IP_OPTS_OFF)) :
                   (even_off != tcp_csum_off));
    hdr_sum_add  = add_hdr ? oc_add(header_sum_r, word) : header_sum_r;
    seg_sum_add  = add_seg ? oc_add(segment_sum_r, word) : segment_sum_r;
  end

  // Summary as it stands after this byte
  always_comb begin
    summary.header_sum   = hdr_sum_add;
    summary.segment_sum  = seg_sum_add;
    summary.total_length = tl_cur;
    summary.header_bytes = hb_cur;
    summary.truncated    = (next_off < 17'd4) || (next_off < {1'b0, tl_cur});
  end

  // Advance state, or clear it once the last byte has gone through
  always_comb begin
    byte_offset_nxt  = byte_offset_r;
    header_bytes_nxt = header_bytes_r;
    total_length_nxt = total_length_r;
    header_sum_nxt   = header_sum_r;
    segment_sum_nxt  = segment_sum_r;
    held_nxt         = held_r;
    if (step_valid) begin
      if (step_last) begin
        byte_offset_nxt  = '0;
        header_bytes_nxt = '0;
        total_length_nxt = '0;
        header_sum_nxt   = '0;
        segment_sum_nxt  = '0;
        held_nxt         = '0;
      end else begin
        byte_offset_nxt  = (byte_offset_r == 16'hffff) ? byte_offset_r : next_off[15:0];
        header_bytes_nxt = hb_cur;
        total_length_nxt = tl_cur;
        header_sum_nxt   = hdr_sum_add;
        segment_sum_nxt  = seg_sum_add;
        if (in_packet && !odd_byte) begin
          held_nxt = step_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= '0;
      header_bytes_r <= '0;
      total_length_r <= '0;
      header_sum_r   <= '0;
      segment_sum_r  <= '0;
      held_r         <= '0;
    end else begin
      byte_offset_r  <= byte_offset_nxt;
      header_bytes_r <= header_bytes_nxt;
      total_length_r <= total_length_nxt;
      header_sum_r   <= header_sum_nxt;
      segment_sum_r  <= segment_sum_nxt;
      held_r         <= held_nxt;
    end
  end

  // Once past the first byte the header length is never below the minimum
  a_hdr_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_offset_r != 16'd0) |-> (header_bytes_r >= MIN_HDR_BYTES))
    else $error("header length below minimum mid-packet");

  // A last byte leaves the accumulator cleared for the next packet
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && step_last) |=>
      (byte_offset_r == 16'd0 && header_sum_r == 16'd0 && segment_sum_r == 16'd0))
    else $error("state not cleared after last byte");

  // The byte offset sticks at its ceiling on very long streams
  a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && !step_last && byte_offset_r == 16'hffff) |=>
      (byte_offset_r == 16'hffff))
    else $error("byte offset wrapped");

endmodule

[hw/rtl/itcr_final.sv]
// Checksum finishing: adds protocol and segment length to the TCP sum, complements both.
// Depends on itcr_pkg for the packet summary type and the protocol number.
module itcr_final
  import itcr_pkg::*;
(
  input  itcr_sum_t   summary,
  output logic [15:0] ip_checksum,
  output logic [15:0] tcp_checksum
);

  logic [15:0] seg_len;
  logic [17:0] sum3;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Pseudo header tail: protocol and segment length, folded twice
  always_comb begin
    seg_len = summary.total_length - {10'd0, summary.header_bytes};
    sum3    = {2'd0, summary.segment_sum} + {2'd0, PROTO_TCP} + {2'd0, seg_len};
    fold1   = {1'b0, sum3[15:0]} + {15'd0, sum3[17:16]};
    fold2   = fold1[15:0] + {15'd0, fold1[16]};
  end

  assign ip_checksum  = ~summary.header_sum;
  assign tcp_checksum = ~fold2;

endmodule

[hw/rtl/ipv4_tcp_checksum_recalc_core.sv]
// IPv4/TCP checksum recalculation core. Takes a packet one byte per item, starting at the
// IPv4 header, and on the item marked tlast gives one result: the IP header checksum,
// the TCP checksum over pseudo header and segment, the total length field and a truncated
// flag. It takes one byte every clock unless a last byte waits; a byte passes an input
// register and is then folded into the running sums, and the result of a last byte is
// loaded into the result register, which drives out_tvalid. Only a last byte waits while
// an earlier result has not been taken. Bytes beyond the total length are ignored.
// Depends on itcr_pkg, itcr_accum and itcr_final.
module ipv4_tcp_checksum_recalc_core
  import itcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] ip_checksum, [31:16] tcp_checksum,
                                             // [47:32] packet_length
  output logic                   out_tuser   // [0] status (1 = truncated)
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       s1_last_r, s1_last_nxt;
  logic       s1_fire;
  logic       res_valid_r, res_valid_nxt;
  itcr_sum_t  res_r, res_nxt;
  itcr_sum_t  summary;
  logic [15:0] ip_csum;
  logic [15:0] tcp_csum;

  // Move the held item on unless it is a last byte blocked by an untaken result
  assign s1_fire   = s1_valid_r && (!s1_last_r || !res_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    s1_last_nxt  = s1_last_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_tdata;
      s1_last_nxt  = in_tlast;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  itcr_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (s1_fire),
    .step_byte  (s1_byte_r),
    .step_last  (s1_last_r),
    .summary    (summary)
  );

  // Result register: load on a last byte, drop once taken
  always_comb begin
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (s1_fire && s1_last_r) begin
      res_valid_nxt = 1'b1;
      res_nxt       = summary;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
    s1_byte_r <= s1_byte_nxt;
    s1_last_r <= s1_last_nxt;
    res_r     <= res_nxt;
  end

  itcr_final u_final (
    .summary      (res_r),
    .ip_checksum  (ip_csum),
    .tcp_checksum (tcp_csum)
  );

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {res_r.total_length, tcp_csum, ip_csum};
  assign out_tuser  = res_r.truncated;

  // A last byte that moves on always lands in the result register
  a_last_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> res_valid_r)
    else $error("last byte processed without a result");

  // A blocked last byte stays put until the earlier result is taken
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && res_valid_r && !out_tready) |=>
      (s1_valid_r && s1_last_r && res_valid_r))
    else $error("blocked last byte lost");

  // A non-last byte never waits
  a_body_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_last_r) |-> in_tready)
    else $error("stream stalled on a body byte");

endmodule
